>>> hdl/box_mean_filter_macros.svh
// Assertion macros used by the box mean filter top level
`ifndef BOX_MEAN_FILTER_MACROS_SVH
`define BOX_MEAN_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BMF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bmf_pkg.sv
// Types, constants and the reciprocal table of the box mean filter
package bmf_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_RADIUS_W = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // 9 samples of 255 per column, 81 per window
    localparam int COLSUM_W    = 12;
    localparam int WINSUM_W    = 15;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = WINSUM_W + RECIP_W;

    typedef logic [PIX_W-1:0]        pixel_t;
    typedef logic [COLSUM_W-1:0]     colsum_t;
    typedef logic [WINSUM_W-1:0]     winsum_t;
    typedef logic [CFG_RADIUS_W-1:0] radius_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } row_ctrl_t;

    // ceil(2^22 / N^2): exact floor division for any window sum below 2^15
    function automatic logic [RECIP_W-1:0] recip_mult(input radius_t r);
        logic [RECIP_W-1:0] m;
        unique case (r)
            3'd1:    m = 19'd466034;
            3'd2:    m = 19'd167773;
            3'd3:    m = 19'd85599;
            3'd4:    m = 19'd51782;
            default: m = 19'd466034;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/bmf_cell.sv
// One column-sum cell of the horizontal window chain
module bmf_cell (
    input  logic               aclk,
    input  bmf_pkg::row_ctrl_t ctrl,
    input  bmf_pkg::colsum_t   din,
    output bmf_pkg::colsum_t   dout
);

    bmf_pkg::colsum_t q_reg;
    bmf_pkg::colsum_t q_next;

    always_comb begin
        q_next = q_reg;
        if (ctrl.clear) begin
            q_next = '0;
        end else if (ctrl.shift) begin
            q_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign dout = q_reg;

endmodule

>>> hdl/bmf_cell_row.sv
// Row of column-sum cells with a running window sum
module bmf_cell_row #(
    parameter int CELLS = 9
) (
    input  logic               aclk,
    input  bmf_pkg::row_ctrl_t ctrl,
    input  bmf_pkg::radius_t   radius,
    input  bmf_pkg::colsum_t   col_sum,
    output bmf_pkg::winsum_t   win_sum
);

    localparam int CIW = $clog2(CELLS);

    bmf_pkg::colsum_t cell_q [CELLS];
    bmf_pkg::colsum_t leave;
    bmf_pkg::winsum_t win_sum_reg;
    bmf_pkg::winsum_t win_sum_next;

    genvar i;
    generate
        for (i = 0; i < CELLS; i++) begin : g_cell
            if (i == 0) begin : g_head
                bmf_cell u_cell (
                    .aclk (aclk),
                    .ctrl (ctrl),
                    .din  (col_sum),
                    .dout (cell_q[i])
                );
            end else begin : g_body
                bmf_cell u_cell (
                    .aclk (aclk),
                    .ctrl (ctrl),
                    .din  (cell_q[i-1]),
                    .dout (cell_q[i])
                );
            end
        end
    endgenerate

    // column that falls off the far edge of the window on a shift
    assign leave = cell_q[CIW'({radius, 1'b0})];

    always_comb begin
        win_sum_next = win_sum_reg;
        if (ctrl.clear) begin
            win_sum_next = '0;
        end else if (ctrl.shift) begin
            win_sum_next = win_sum_reg + bmf_pkg::WINSUM_W'(col_sum)
                         - bmf_pkg::WINSUM_W'(leave);
        end
    end

    always_ff @(posedge aclk) begin
        win_sum_reg <= win_sum_next;
    end

    assign win_sum = win_sum_reg;

endmodule

>>> hdl/bmf_line_store.sv
// Line store: one write port, one registered read port
module bmf_line_store #(
    parameter int DEPTH = 10240,
    parameter int AW    = 14
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  bmf_pkg::pixel_t  wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output bmf_pkg::pixel_t  rdata
);

    bmf_pkg::pixel_t mem [DEPTH];
    bmf_pkg::pixel_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/box_mean_filter.sv
// Top level of the zero-padded centred box mean filter
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata[7:0] pixel, s_tuser drain
//  m_        out        m_tvalid / m_tready    m_tdata[7:0] smoothed, m_tlast last
//  cfg_      in         cfg_wr_en (no wait)    cfg_addr register index, cfg_wdata value
//
// One word is worked on at a time; s_tready is high only when the control is idle.
// A word that gives no result goes through the check state back to idle; a drain
// inside the frame is ignored in idle. Inside a row, 2R+1 line store reads, one per
// cycle, build the column sum entering the window. A result at the start of a row
// builds R+1 columns; columns past the right edge skip the reads and enter as zero.
// Synchronous active-low reset, then the setup state derives the frame constants;
// setup also follows every register write. The line store needs no clear.
// A finished word waits in the output register while the next input is taken;
// only a second result stalls on m_tready.
`include "box_mean_filter_macros.svh"

module box_mean_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel
    input  logic                            s_tuser,   // [0] drain
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] smoothed
    output logic                            m_tlast
);

    localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int CELLS     = 2 * MAX_RADIUS + 1;
    localparam int SW        = $clog2(LINE_ROWS);
    localparam int AW        = $clog2(LINE_ROWS * MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int RRW       = RW + 2;
    localparam int XW        = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int NW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int TW        = $clog2(CELLS);
    localparam int RDW       = bmf_pkg::CFG_RADIUS_W;

    localparam logic [3:0] ST_SETUP = 4'd0;   // derive frame constants
    localparam logic [3:0] ST_IDLE  = 4'd1;   // take an input word
    localparam logic [3:0] ST_CHECK = 4'd2;   // decide whether a result is due
    localparam logic [3:0] ST_COL   = 4'd3;   // start one column sum
    localparam logic [3:0] ST_READ  = 4'd4;   // read one window row a cycle
    localparam logic [3:0] ST_LAST  = 4'd5;   // collect the final read
    localparam logic [3:0] ST_SHIFT = 4'd6;   // push the column into the cells
    localparam logic [3:0] ST_MUL   = 4'd7;   // multiply by 1/N^2
    localparam logic [3:0] ST_OUT   = 4'd8;   // load the output register

    // ---------------------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------------------
    logic [3:0]                        state_reg, state_next;
    logic [bmf_pkg::CFG_WIDTH_W-1:0]   cfg_width_reg, cfg_width_next;
    logic [bmf_pkg::CFG_HEIGHT_W-1:0]  cfg_height_reg, cfg_height_next;
    bmf_pkg::radius_t                  cfg_radius_reg, cfg_radius_next;

    // clamped registers and derived frame constants
    logic [WW-1:0]                     w_reg, w_next;
    logic [HW-1:0]                     h_reg, h_next;
    bmf_pkg::radius_t                  r_reg, r_next;
    logic [NW-1:0]                     total_reg, total_next;
    logic [NW-1:0]                     lag_reg, lag_next;

    // input raster position
    logic [NW-1:0]                     in_count_reg, in_count_next;
    logic [CW-1:0]                     in_col_reg, in_col_next;
    logic [SW-1:0]                     in_slot_reg, in_slot_next;

    // output raster position
    logic [NW-1:0]                     out_count_reg, out_count_next;
    logic [CW-1:0]                     ocol_reg, ocol_next;
    logic [RW-1:0]                     orow_reg, orow_next;
    logic [SW-1:0]                     oslot_reg, oslot_next;

    // column sequencer
    logic [XW-1:0]                     col_reg, col_next;
    logic [RDW-1:0]                    cols_left_reg, cols_left_next;
    logic [TW-1:0]                     tap_reg, tap_next;
    logic [RRW-1:0]                    rrow_reg, rrow_next;
    logic [SW-1:0]                     rslot_reg, rslot_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic                              rd_mask_reg, rd_mask_next;
    bmf_pkg::colsum_t                  acc_reg, acc_next;
    logic [bmf_pkg::PROD_W-1:0]        prod_reg, prod_next;

    // output register
    logic                              m_tvalid_reg, m_tvalid_next;
    bmf_pkg::pixel_t                   m_tdata_reg, m_tdata_next;
    logic                              m_tlast_reg, m_tlast_next;

    // ---------------------------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------------------------
    logic [WW-1:0]                     w_clamp;
    logic [HW-1:0]                     h_clamp;
    bmf_pkg::radius_t                  r_clamp;
    logic                              in_frame;
    logic [NW:0]                       target_sum;
    logic [NW-1:0]                     target;
    logic                              due;
    logic                              row_ok;
    logic [SW:0]                       slot_diff;
    logic [SW-1:0]                     slot_start;
    logic                              last_now;
    logic                              out_load;
    logic                              mem_we;
    logic                              rd_en;
    logic [AW-1:0]                     waddr;
    logic [AW-1:0]                     raddr;
    bmf_pkg::pixel_t                   rd_data;
    bmf_pkg::winsum_t                  win_sum;
    bmf_pkg::row_ctrl_t                row_ctrl;

    // zero acts as 1, anything above the maximum acts as the maximum
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_clamp = WW'(1);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(cfg_width_reg);
        end
        if (cfg_height_reg == '0) begin
            h_clamp = HW'(1);
        end else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(cfg_height_reg);
        end
        if (cfg_radius_reg == '0) begin
            r_clamp = RDW'(1);
        end else if (32'(cfg_radius_reg) > 32'(MAX_RADIUS)) begin
            r_clamp = RDW'(MAX_RADIUS);
        end else begin
            r_clamp = cfg_radius_reg;
        end
    end

    assign in_frame   = in_count_reg < total_reg;
    // a result is due once every pixel of its window is in, capped at the frame end
    assign target_sum = (NW+1)'(out_count_reg) + (NW+1)'(lag_reg);
    assign target     = (target_sum > (NW+1)'(total_reg)) ? total_reg : NW'(target_sum);
    assign due        = in_count_reg >= target;
    // rows above the top or below the bottom of the image count as zero
    assign row_ok     = !rrow_reg[RRW-1] && ((RRW-1)'(rrow_reg) < (RRW-1)'(h_reg));
    // slot of the window's top row, taken modulo the number of stored rows
    assign slot_diff  = {1'b0, oslot_reg} - (SW+1)'(r_reg);
    assign slot_start = slot_diff[SW] ? SW'(slot_diff + (SW+1)'(LINE_ROWS)) : SW'(slot_diff);
    assign last_now   = (out_count_reg + NW'(1)) == total_reg;

    assign waddr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign raddr = AW'(rslot_reg) * AW'(MAX_WIDTH) + AW'(col_reg);

    // ---------------------------------------------------------------------------------
    // next-state logic
    // ---------------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        cfg_radius_next = cfg_radius_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        r_next          = r_reg;
        total_next      = total_reg;
        lag_next        = lag_reg;
        in_count_next   = in_count_reg;
        in_col_next     = in_col_reg;
        in_slot_next    = in_slot_reg;
        out_count_next  = out_count_reg;
        ocol_next       = ocol_reg;
        orow_next       = orow_reg;
        oslot_next      = oslot_reg;
        col_next        = col_reg;
        cols_left_next  = cols_left_reg;
        tap_next        = tap_reg;
        rrow_next       = rrow_reg;
        rslot_next      = rslot_reg;
        rd_mask_next    = rd_mask_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        // drop the output word once it is taken
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        out_load        = 1'b0;
        row_ctrl        = '0;

        // add the word read in the previous cycle to the column sum
        if (rd_pend_reg && rd_mask_reg) begin
            acc_next = acc_reg + bmf_pkg::COLSUM_W'(rd_data);
        end

        unique case (state_reg)
            ST_SETUP: begin
                w_next     = w_clamp;
                h_next     = h_clamp;
                r_next     = r_clamp;
                total_next = NW'(w_clamp) * NW'(h_clamp);
                lag_next   = NW'(r_clamp) * NW'(w_clamp) + NW'(r_clamp) + NW'(1);
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!in_frame) begin
                        // frame complete: a pixel is dropped and acts as a drain
                        state_next = ST_CHECK;
                    end else if (!s_tuser) begin
                        mem_we        = 1'b1;
                        in_count_next = in_count_reg + NW'(1);
                        if ((WW'(in_col_reg) + WW'(1)) == w_reg) begin
                            in_col_next  = '0;
                            in_slot_next = (in_slot_reg == SW'(LINE_ROWS - 1)) ?
                                           '0 : in_slot_reg + SW'(1);
                        end else begin
                            in_col_next = in_col_reg + CW'(1);
                        end
                        state_next = ST_CHECK;
                    end
                    // a drain inside the frame is ignored
                end
            end
            ST_CHECK: begin
                if (due) begin
                    if (ocol_reg == '0) begin
                        // row start: clear the cells and fill columns 0 .. R
                        row_ctrl.clear = 1'b1;
                        col_next       = '0;
                        cols_left_next = r_reg;
                    end else begin
                        col_next       = XW'(ocol_reg) + XW'(r_reg);
                        cols_left_next = '0;
                    end
                    state_next = ST_COL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_COL: begin
                acc_next = '0;
                if (col_reg < XW'(w_reg)) begin
                    tap_next   = '0;
                    rrow_next  = RRW'(orow_reg) - RRW'(r_reg);
                    rslot_next = slot_start;
                    state_next = ST_READ;
                end else begin
                    // column past the right edge enters as zero
                    state_next = ST_SHIFT;
                end
            end
            ST_READ: begin
                rd_en        = 1'b1;
                rd_mask_next = row_ok;
                tap_next     = tap_reg + TW'(1);
                rrow_next    = rrow_reg + RRW'(1);
                rslot_next   = (rslot_reg == SW'(LINE_ROWS - 1)) ? '0 : rslot_reg + SW'(1);
                if (tap_reg == TW'({r_reg, 1'b0})) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                row_ctrl.shift = 1'b1;
                if (cols_left_reg != '0) begin
                    cols_left_next = cols_left_reg - RDW'(1);
                    col_next       = col_reg + XW'(1);
                    state_next     = ST_COL;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = bmf_pkg::PROD_W'(win_sum)
                           * bmf_pkg::PROD_W'(bmf_pkg::recip_mult(r_reg));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = prod_reg[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];
                    m_tlast_next  = last_now;
                    if (last_now) begin
                        in_count_next  = '0;
                        in_col_next    = '0;
                        in_slot_next   = '0;
                        out_count_next = '0;
                        ocol_next      = '0;
                        orow_next      = '0;
                        oslot_next     = '0;
                    end else begin
                        out_count_next = out_count_reg + NW'(1);
                        if ((WW'(ocol_reg) + WW'(1)) == w_reg) begin
                            ocol_next  = '0;
                            orow_next  = orow_reg + RW'(1);
                            oslot_next = (oslot_reg == SW'(LINE_ROWS - 1)) ?
                                         '0 : oslot_reg + SW'(1);
                        end else begin
                            ocol_next = ocol_reg + CW'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SETUP;
            end
        endcase

        // a register write restarts the frame; stored pixels are kept
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                bmf_pkg::CFG_IMAGE_WIDTH:
                    cfg_width_next  = cfg_wdata[bmf_pkg::CFG_WIDTH_W-1:0];
                bmf_pkg::CFG_IMAGE_HEIGHT:
                    cfg_height_next = cfg_wdata[bmf_pkg::CFG_HEIGHT_W-1:0];
                bmf_pkg::CFG_WINDOW_RADIUS:
                    cfg_radius_next = cfg_wdata[bmf_pkg::CFG_RADIUS_W-1:0];
                default: ;
            endcase
            if (cfg_addr == bmf_pkg::CFG_IMAGE_WIDTH || cfg_addr == bmf_pkg::CFG_IMAGE_HEIGHT
                || cfg_addr == bmf_pkg::CFG_WINDOW_RADIUS) begin
                in_count_next  = '0;
                in_col_next    = '0;
                in_slot_next   = '0;
                out_count_next = '0;
                ocol_next      = '0;
                orow_next      = '0;
                oslot_next     = '0;
                state_next     = ST_SETUP;
            end
        end
    end

    assign rd_pend_next = rd_en;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SETUP;
            cfg_width_reg  <= bmf_pkg::CFG_WIDTH_W'(1);
            cfg_height_reg <= bmf_pkg::CFG_HEIGHT_W'(1);
            cfg_radius_reg <= RDW'(1);
            in_count_reg   <= '0;
            in_col_reg     <= '0;
            in_slot_reg    <= '0;
            out_count_reg  <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            oslot_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            cfg_radius_reg <= cfg_radius_next;
            in_count_reg   <= in_count_next;
            in_col_reg     <= in_col_next;
            in_slot_reg    <= in_slot_next;
            out_count_reg  <= out_count_next;
            ocol_reg       <= ocol_next;
            orow_reg       <= orow_next;
            oslot_reg      <= oslot_next;
            rd_pend_reg    <= rd_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload and derived values
    always_ff @(posedge aclk) begin
        w_reg         <= w_next;
        h_reg         <= h_next;
        r_reg         <= r_next;
        total_reg     <= total_next;
        lag_reg       <= lag_next;
        col_reg       <= col_next;
        cols_left_reg <= cols_left_next;
        tap_reg       <= tap_next;
        rrow_reg      <= rrow_next;
        rslot_reg     <= rslot_next;
        rd_mask_reg   <= rd_mask_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    // ---------------------------------------------------------------------------------
    // line store and cell row
    // ---------------------------------------------------------------------------------
    bmf_line_store #(
        .DEPTH (LINE_ROWS * MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_data)
    );

    bmf_cell_row #(
        .CELLS (CELLS)
    ) u_cell_row (
        .aclk    (aclk),
        .ctrl    (row_ctrl),
        .radius  (r_reg),
        .col_sum (acc_reg),
        .win_sum (win_sum)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------
    `BMF_ASSERT_SAME(a_out_behind_in, aclk, aresetn, 1'b1, out_count_reg <= in_count_reg, "result count ran ahead of input count")
    `BMF_ASSERT_SAME(a_read_in_frame, aclk, aresetn, state_reg == ST_READ, col_reg < XW'(w_reg), "line store read beyond the image width")
    `BMF_ASSERT_SAME(a_shift_after_collect, aclk, aresetn, row_ctrl.shift, !rd_pend_reg, "column shifted before its last read was summed")
    `BMF_ASSERT_NEXT(a_last_restarts, aclk, aresetn, out_load && m_tlast_next, (in_count_reg == '0) && (out_count_reg == '0), "frame not restarted after the last word")

endmodule
